FILE: rtl/core/circular_angle_interpolator_unit_macros.svh
// assertion macros for the circular angle interpolator
// no dependencies; included by the checker file
`ifndef CIRCULAR_ANGLE_INTERPOLATOR_UNIT_MACROS_SVH
`define CIRCULAR_ANGLE_INTERPOLATOR_UNIT_MACROS_SVH

// property checked only outside reset
`define CAI_ASSERT(lbl, ck, rs, prop) \
  lbl: assert property (@(posedge ck) disable iff (rs) prop) \
    else $error("cai assertion failed");

// property checked at every edge, reset included
`define CAI_ASSERT_ALWAYS(lbl, ck, prop) \
  lbl: assert property (@(posedge ck) prop) \
    else $error("cai assertion failed");

`endif

FILE: rtl/core/cai_pkg.sv
// shared types, constants and the arctangent table for the angle interpolator
// no dependencies
package cai_pkg;

  localparam int TABLE_DEPTH   = 1024;
  localparam int CORDIC_STAGES = 18;
  localparam int ADDR_W        = $clog2(TABLE_DEPTH);

  localparam int ANG_W   = 20;
  localparam int POS_W   = 32;
  localparam int LEN_W   = 11;
  localparam int BIN_W   = 11;
  localparam int IDX_W   = 10;
  localparam int FRAC_W  = 16;
  localparam int RATIO_W = FRAC_W + 1;
  localparam int DIV_STEPS = RATIO_W;
  localparam int CHAIN_LEN = (CORDIC_STAGES > DIV_STEPS) ? CORDIC_STAGES : DIV_STEPS;
  localparam int SH_W    = 5;
  localparam int CW      = 36;
  localparam int DW      = CW + 1;
  localparam int PROD_W  = DW + RATIO_W + 1;
  localparam int LPROD_W = ANG_W + 1 + RATIO_W + 1;

  // cycles from the accept edge to the edge that takes the result
  localparam int LATENCY = 9 + CHAIN_LEN + CORDIC_STAGES;

  localparam logic signed [CW-1:0] ONE_Q30     = 36'sd1073741824;
  localparam logic signed [CW-1:0] PI_Q30      = 36'sd3373259426;
  localparam logic signed [CW-1:0] HALF_PI_Q30 = 36'sd1686629713;
  localparam logic signed [CW-1:0] TWO_PI_Q30  = 36'sd6746518852;
  localparam logic signed [CW-1:0] ANGLE_MAX   = 36'sd524287;
  localparam logic signed [CW-1:0] ANGLE_MIN   = -36'sd524288;
  localparam logic signed [ANG_W:0] PI_LIMIT   = 21'sd205887;
  localparam logic [RATIO_W-1:0]   RATIO_ONE   = 17'h10000;

  localparam logic ACT_LOAD  = 1'b0;
  localparam logic ACT_QUERY = 1'b1;

  typedef enum logic [2:0] {
    CASE_BEFORE   = 3'd0,
    CASE_PAST     = 3'd1,
    CASE_LEFT     = 3'd2,
    CASE_RIGHT    = 3'd3,
    CASE_LINEAR   = 3'd4,
    CASE_CIRCULAR = 3'd5
  } case_t;

  typedef struct packed {
    logic                    action;
    logic [IDX_W-1:0]        entry_index;
    logic [POS_W-1:0]        sample_position;
    logic signed [ANG_W-1:0] sample_angle;
    logic [POS_W-1:0]        query_position;
    logic [BIN_W-1:0]        query_bin;
    logic                    query_last;
  } req_t;

  typedef struct packed {
    logic signed [ANG_W-1:0] result_angle;
    logic [2:0]              case_code;
    logic                    ratio_fault;
    logic                    last_of_batch;
  } res_t;

  typedef struct packed {
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic signed [CW-1:0] z;
  } vec_t;

  typedef struct packed {
    logic [POS_W-1:0]   den;
    logic [POS_W-1:0]   rem;
    logic [RATIO_W-1:0] quo;
  } div_t;

  function automatic logic signed [CW-1:0] atan_q30(input logic [SH_W-1:0] i);
    logic signed [CW-1:0] a;
    unique case (i)
      5'd0:  a = 36'sd843314857;
      5'd1:  a = 36'sd497837829;
      5'd2:  a = 36'sd263043837;
      5'd3:  a = 36'sd133525159;
      5'd4:  a = 36'sd67021687;
      5'd5:  a = 36'sd33543516;
      5'd6:  a = 36'sd16775851;
      5'd7:  a = 36'sd8388437;
      5'd8:  a = 36'sd4194283;
      5'd9:  a = 36'sd2097149;
      5'd10: a = 36'sd1048576;
      5'd11: a = 36'sd524288;
      5'd12: a = 36'sd262144;
      5'd13: a = 36'sd131072;
      5'd14: a = 36'sd65536;
      5'd15: a = 36'sd32768;
      5'd16: a = 36'sd16384;
      5'd17: a = 36'sd8192;
      5'd18: a = 36'sd4096;
      5'd19: a = 36'sd2048;
      5'd20: a = 36'sd1024;
      5'd21: a = 36'sd512;
      5'd22: a = 36'sd256;
      5'd23: a = 36'sd128;
      5'd24: a = 36'sd64;
      5'd25: a = 36'sd32;
      5'd26: a = 36'sd16;
      5'd27: a = 36'sd8;
      5'd28: a = 36'sd4;
      5'd29: a = 36'sd2;
      5'd30: a = 36'sd1;
      5'd31: a = 36'sd0;
      default: a = 36'sd0;
    endcase
    return a;
  endfunction

endpackage

FILE: rtl/core/circular_angle_interpolator_unit.sv
// pipeline from the accept edge to the edge that takes the result
// (9 fixed stages, a 18-cell divider/rotation chain, 18 vectoring cells)
// throughput: one transaction per cycle, busy never rises; loads give no result
// a query may read an entry loaded in any earlier cycle
// rst (synchronous) clears the pipeline valids and sets table_length to 1024
// depends on cai_pkg, cai_div_cell, cai_rot_cell, cai_vec_cell
module circular_angle_interpolator_unit (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  output logic                      busy,
  input  cai_pkg::req_t             request,
  output logic                      done,
  output cai_pkg::res_t             result,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [cai_pkg::LEN_W-1:0] cfg_data
);
  import cai_pkg::*;

  typedef struct packed {
    case_t                   code;
    logic                    last;
    logic signed [ANG_W-1:0] direct;
    logic signed [ANG_W-1:0] a0;
    logic signed [ANG_W-1:0] a1;
    logic                    rz;
    logic                    sat;
    logic                    flip0;
    logic                    flip1;
  } chain_sb_t;

  typedef struct packed {
    case_t                   code;
    logic                    fault;
    logic                    last;
    logic signed [ANG_W-1:0] direct;
    logic signed [ANG_W-1:0] lin;
    logic                    vzero;
  } tail_sb_t;

  logic             accept;
  logic [LEN_W-1:0] table_length;
  logic [LEN_W-1:0] len_eff;
  logic [LEN_W-1:0] len_m1;
  logic [BIN_W-1:0] bin_m1, bin_m2;
  logic             below, past;
  logic [ADDR_W-1:0] addr_a, addr_b, wr_addr;

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;
  assign accept    = start && !busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      table_length <= LEN_W'(TABLE_DEPTH);
    end else if (cfg_valid && cfg_ready) begin
      table_length <= cfg_data;
    end
  end

  always_comb begin
    if (table_length == '0) begin
      len_eff = LEN_W'(1);
    end else if (int'(table_length) > TABLE_DEPTH) begin
      len_eff = LEN_W'(TABLE_DEPTH);
    end else begin
      len_eff = table_length;
    end
    len_m1 = len_eff - LEN_W'(1);
    bin_m1 = request.query_bin - BIN_W'(1);
    bin_m2 = request.query_bin - BIN_W'(2);
    below  = request.query_bin < BIN_W'(2);
    past   = !below && (bin_m1 >= len_eff);
    priority if (below) begin
      addr_a = '0;
    end else if (past) begin
      addr_a = len_m1[ADDR_W-1:0];
    end else begin
      addr_a = bin_m2[ADDR_W-1:0];
    end
    addr_b  = bin_m1[ADDR_W-1:0];
    wr_addr = ADDR_W'(request.entry_index);
  end

  // position and angle table, one write and two reads per cycle
  logic [POS_W+ANG_W-1:0] tbl [TABLE_DEPTH];
  logic [POS_W+ANG_W-1:0] rd_a, rd_b;

  always_ff @(posedge clk) begin
    if (accept && request.action == ACT_LOAD &&
        int'(request.entry_index) < TABLE_DEPTH) begin
      tbl[wr_addr] <= {request.sample_position, request.sample_angle};
    end
  end

  always_ff @(posedge clk) begin
    rd_a <= tbl[addr_a];
    rd_b <= tbl[addr_b];
  end

  // stage 1: table read
  logic             v1, below1, past1, last1;
  logic [POS_W-1:0] xp1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else begin
      v1 <= accept && request.action == ACT_QUERY;
    end
  end

  always_ff @(posedge clk) begin
    xp1    <= request.query_position;
    below1 <= below;
    past1  <= past;
    last1  <= request.query_last;
  end

  // stage 2: case selection, differences, angle reduction
  logic [POS_W-1:0]        pa, pb;
  logic signed [ANG_W-1:0] aa, ab;
  logic signed [POS_W:0]   num_c, den_c;
  logic signed [ANG_W:0]   dang, adang;
  logic signed [CW-1:0]    zt0, zt1, zr0, zr1;
  case_t                   code_c;

  assign pa = rd_a[POS_W+ANG_W-1:ANG_W];
  assign pb = rd_b[POS_W+ANG_W-1:ANG_W];
  assign aa = rd_a[ANG_W-1:0];
  assign ab = rd_b[ANG_W-1:0];

  always_comb begin
    num_c = $signed({1'b0, xp1}) - $signed({1'b0, pa});
    den_c = $signed({1'b0, pb}) - $signed({1'b0, pa});
    dang  = (ANG_W+1)'(aa) - (ANG_W+1)'(ab);
    adang = dang[ANG_W] ? -dang : dang;
    priority if (below1) begin
      code_c = CASE_BEFORE;
    end else if (past1) begin
      code_c = CASE_PAST;
    end else if (xp1 == pa) begin
      code_c = CASE_LEFT;
    end else if (xp1 == pb) begin
      code_c = CASE_RIGHT;
    end else if (adang > PI_LIMIT) begin
      code_c = CASE_CIRCULAR;
    end else begin
      code_c = CASE_LINEAR;
    end
    zt0 = CW'(aa) <<< 14;
    zt1 = CW'(ab) <<< 14;
    priority if (zt0 > PI_Q30) begin
      zr0 = zt0 - TWO_PI_Q30;
    end else if (zt0 < -PI_Q30) begin
      zr0 = zt0 + TWO_PI_Q30;
    end else begin
      zr0 = zt0;
    end
    priority if (zt1 > PI_Q30) begin
      zr1 = zt1 - TWO_PI_Q30;
    end else if (zt1 < -PI_Q30) begin
      zr1 = zt1 + TWO_PI_Q30;
    end else begin
      zr1 = zt1;
    end
  end

  logic                    v2, last2;
  case_t                   code2;
  logic signed [ANG_W-1:0] direct2, a0_2, a1_2;
  logic signed [POS_W:0]   num2, den2;
  logic signed [CW-1:0]    z0_2, z1_2;

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    code2   <= code_c;
    last2   <= last1;
    direct2 <= (code_c == CASE_RIGHT) ? ab : aa;
    a0_2    <= aa;
    a1_2    <= ab;
    num2    <= num_c;
    den2    <= den_c;
    z0_2    <= zr0;
    z1_2    <= zr1;
  end

  // stage 3: magnitudes, sign fault, fold into the right half plane
  logic signed [POS_W:0] un_w, ud_w;
  logic signed [CW-1:0]  zf0, zf1;
  logic                  fl0, fl1;

  always_comb begin
    un_w = num2[POS_W] ? -num2 : num2;
    ud_w = den2[POS_W] ? -den2 : den2;
    priority if (z0_2 > HALF_PI_Q30) begin
      zf0 = z0_2 - PI_Q30;
      fl0 = 1'b1;
    end else if (z0_2 < -HALF_PI_Q30) begin
      zf0 = z0_2 + PI_Q30;
      fl0 = 1'b1;
    end else begin
      zf0 = z0_2;
      fl0 = 1'b0;
    end
    priority if (z1_2 > HALF_PI_Q30) begin
      zf1 = z1_2 - PI_Q30;
      fl1 = 1'b1;
    end else if (z1_2 < -HALF_PI_Q30) begin
      zf1 = z1_2 + PI_Q30;
      fl1 = 1'b1;
    end else begin
      zf1 = z1_2;
      fl1 = 1'b0;
    end
  end

  logic                    v3, last3, rz3, flip0_3, flip1_3;
  case_t                   code3;
  logic signed [ANG_W-1:0] direct3, a0_3, a1_3;
  logic [POS_W-1:0]        un3, ud3;
  logic signed [CW-1:0]    z0_3, z1_3;

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else begin
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    code3   <= code2;
    last3   <= last2;
    direct3 <= direct2;
    a0_3    <= a0_2;
    a1_3    <= a1_2;
    un3     <= un_w[POS_W-1:0];
    ud3     <= ud_w[POS_W-1:0];
    rz3     <= (den2 == '0) || (num2[POS_W] != den2[POS_W]);
    z0_3    <= zf0;
    z1_3    <= zf1;
    flip0_3 <= fl0;
    flip1_3 <= fl1;
  end

  // stage 4: saturation test and chain entry
  logic [POS_W+FRAC_W:0] sat_lhs, sat_rhs;

  assign sat_lhs = {1'b0, un3, {FRAC_W{1'b0}}};
  assign sat_rhs = {1'b0, ud3, {FRAC_W{1'b0}}} + (POS_W+FRAC_W+1)'(ud3);

  logic            chain_v   [CHAIN_LEN+1];
  chain_sb_t       chain_sb  [CHAIN_LEN+1];
  div_t            div_d     [CHAIN_LEN+1];
  vec_t            rot0_d    [CHAIN_LEN+1];
  vec_t            rot1_d    [CHAIN_LEN+1];
  logic            first_bit;

  always_ff @(posedge clk) begin
    if (rst) begin
      chain_v[0] <= 1'b0;
    end else begin
      chain_v[0] <= v3;
    end
  end

  always_ff @(posedge clk) begin
    chain_sb[0].code   <= code3;
    chain_sb[0].last   <= last3;
    chain_sb[0].direct <= direct3;
    chain_sb[0].a0     <= a0_3;
    chain_sb[0].a1     <= a1_3;
    chain_sb[0].rz     <= rz3;
    chain_sb[0].sat    <= sat_lhs >= sat_rhs;
    chain_sb[0].flip0  <= flip0_3;
    chain_sb[0].flip1  <= flip1_3;
    div_d[0].den       <= ud3;
    div_d[0].rem       <= {1'b0, un3[POS_W-1:1]};
    div_d[0].quo       <= '0;
    first_bit          <= un3[0];
    rot0_d[0].x        <= ONE_Q30;
    rot0_d[0].y        <= '0;
    rot0_d[0].z        <= z0_3;
    rot1_d[0].x        <= ONE_Q30;
    rot1_d[0].y        <= '0;
    rot1_d[0].z        <= z1_3;
  end

  // divider and unit-vector cells side by side
  for (genvar k = 0; k < CHAIN_LEN; k++) begin : g_chain
    cai_div_cell u_div (
      .clk    (clk),
      .en     (k < DIV_STEPS),
      .bit_in ((k == 0) ? first_bit : 1'b0),
      .d      (div_d[k]),
      .q      (div_d[k+1])
    );
    cai_rot_cell u_rot0 (
      .clk (clk),
      .en  (k < CORDIC_STAGES),
      .idx (SH_W'(k)),
      .v   (rot0_d[k]),
      .q   (rot0_d[k+1])
    );
    cai_rot_cell u_rot1 (
      .clk (clk),
      .en  (k < CORDIC_STAGES),
      .idx (SH_W'(k)),
      .v   (rot1_d[k]),
      .q   (rot1_d[k+1])
    );
    always_ff @(posedge clk) begin
      if (rst) begin
        chain_v[k+1] <= 1'b0;
      end else begin
        chain_v[k+1] <= chain_v[k];
      end
    end
    always_ff @(posedge clk) begin
      chain_sb[k+1] <= chain_sb[k];
    end
  end

  // post stage 1: ratio and differences
  chain_sb_t            ce;
  vec_t                 r0e, r1e;
  logic signed [CW-1:0] c0_c, s0_c, c1_c, s1_c;
  logic [RATIO_W-1:0]   ratio_c;
  logic                 fault_c;

  assign ce  = chain_sb[CHAIN_LEN];
  assign r0e = rot0_d[CHAIN_LEN];
  assign r1e = rot1_d[CHAIN_LEN];

  always_comb begin
    c0_c = ce.flip0 ? -r0e.x : r0e.x;
    s0_c = ce.flip0 ? -r0e.y : r0e.y;
    c1_c = ce.flip1 ? -r1e.x : r1e.x;
    s1_c = ce.flip1 ? -r1e.y : r1e.y;
    priority if (ce.rz) begin
      ratio_c = '0;
    end else if (ce.sat) begin
      ratio_c = RATIO_ONE;
    end else begin
      ratio_c = div_d[CHAIN_LEN].quo;
    end
    fault_c = (ce.code == CASE_LINEAR || ce.code == CASE_CIRCULAR) && (ce.rz || ce.sat);
  end

  logic                    p1_v;
  tail_sb_t                p1_sb;
  logic [RATIO_W-1:0]      p1_ratio;
  logic signed [CW-1:0]    p1_c0, p1_s0;
  logic signed [DW-1:0]    p1_dc, p1_ds;
  logic signed [ANG_W-1:0] p1_a0;
  logic signed [ANG_W:0]   p1_da;

  always_ff @(posedge clk) begin
    if (rst) begin
      p1_v <= 1'b0;
    end else begin
      p1_v <= chain_v[CHAIN_LEN];
    end
  end

  always_ff @(posedge clk) begin
    p1_sb.code   <= ce.code;
    p1_sb.fault  <= fault_c;
    p1_sb.last   <= ce.last;
    p1_sb.direct <= ce.direct;
    p1_sb.lin    <= '0;
    p1_sb.vzero  <= 1'b0;
    p1_ratio     <= ratio_c;
    p1_c0        <= c0_c;
    p1_s0        <= s0_c;
    p1_dc        <= DW'(c1_c) - DW'(c0_c);
    p1_ds        <= DW'(s1_c) - DW'(s0_c);
    p1_a0        <= ce.a0;
    p1_da        <= (ANG_W+1)'(ce.a1) - (ANG_W+1)'(ce.a0);
  end

  // post stage 2: products
  logic                      p2_v;
  tail_sb_t                  p2_sb;
  logic signed [CW-1:0]      p2_c0, p2_s0;
  logic signed [ANG_W-1:0]   p2_a0;
  logic signed [PROD_W-1:0]  p2_pc, p2_ps;
  logic signed [LPROD_W-1:0] p2_pa;

  always_ff @(posedge clk) begin
    if (rst) begin
      p2_v <= 1'b0;
    end else begin
      p2_v <= p1_v;
    end
  end

  always_ff @(posedge clk) begin
    p2_sb <= p1_sb;
    p2_c0 <= p1_c0;
    p2_s0 <= p1_s0;
    p2_a0 <= p1_a0;
    p2_pc <= $signed({1'b0, p1_ratio}) * p1_dc;
    p2_ps <= $signed({1'b0, p1_ratio}) * p1_ds;
    p2_pa <= $signed({1'b0, p1_ratio}) * p1_da;
  end

  // post stage 3: rounded interpolation
  logic signed [PROD_W-1:0]  rc, rs;
  logic signed [LPROD_W-1:0] rl;
  tail_sb_t                  p3_sb_next;

  always_comb begin
    rc = (p2_pc + PROD_W'(32768)) >>> FRAC_W;
    rs = (p2_ps + PROD_W'(32768)) >>> FRAC_W;
    rl = (p2_pa + LPROD_W'(32768)) >>> FRAC_W;
    p3_sb_next     = p2_sb;
    p3_sb_next.lin = p2_a0 + rl[ANG_W-1:0];
  end

  logic                 p3_v;
  tail_sb_t             p3_sb;
  logic signed [CW-1:0] p3_c, p3_s;

  always_ff @(posedge clk) begin
    if (rst) begin
      p3_v <= 1'b0;
    end else begin
      p3_v <= p2_v;
    end
  end

  always_ff @(posedge clk) begin
    p3_sb <= p3_sb_next;
    p3_c  <= p2_c0 + rc[CW-1:0];
    p3_s  <= p2_s0 + rs[CW-1:0];
  end

  // post stage 4: left half plane folded by pi
  logic     vec_v  [CORDIC_STAGES+1];
  tail_sb_t vec_sb [CORDIC_STAGES+1];
  vec_t     vec_d  [CORDIC_STAGES+1];
  tail_sb_t vec_sb_first;

  always_comb begin
    vec_sb_first       = p3_sb;
    vec_sb_first.vzero = (p3_c == '0) && (p3_s == '0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vec_v[0] <= 1'b0;
    end else begin
      vec_v[0] <= p3_v;
    end
  end

  always_ff @(posedge clk) begin
    vec_sb[0] <= vec_sb_first;
    if (p3_c[CW-1]) begin
      vec_d[0].x <= -p3_c;
      vec_d[0].y <= -p3_s;
      vec_d[0].z <= p3_s[CW-1] ? -PI_Q30 : PI_Q30;
    end else begin
      vec_d[0].x <= p3_c;
      vec_d[0].y <= p3_s;
      vec_d[0].z <= '0;
    end
  end

  for (genvar k = 0; k < CORDIC_STAGES; k++) begin : g_vec
    cai_vec_cell u_vec (
      .clk (clk),
      .idx (SH_W'(k)),
      .v   (vec_d[k]),
      .q   (vec_d[k+1])
    );
    always_ff @(posedge clk) begin
      if (rst) begin
        vec_v[k+1] <= 1'b0;
      end else begin
        vec_v[k+1] <= vec_v[k];
      end
    end
    always_ff @(posedge clk) begin
      vec_sb[k+1] <= vec_sb[k];
    end
  end

  // output stage: round to q16, saturate, pick the answer
  tail_sb_t                fe;
  logic signed [CW-1:0]    zr;
  logic signed [ANG_W-1:0] circ_ang;
  res_t                    res_next;

  assign fe = vec_sb[CORDIC_STAGES];

  always_comb begin
    zr = (vec_d[CORDIC_STAGES].z + CW'(8192)) >>> 14;
    priority if (fe.vzero) begin
      circ_ang = '0;
    end else if (zr > ANGLE_MAX) begin
      circ_ang = ANGLE_MAX[ANG_W-1:0];
    end else if (zr < ANGLE_MIN) begin
      circ_ang = ANGLE_MIN[ANG_W-1:0];
    end else begin
      circ_ang = zr[ANG_W-1:0];
    end
    res_next.case_code     = fe.code;
    res_next.ratio_fault   = fe.fault;
    res_next.last_of_batch = fe.last;
    unique case (fe.code)
      CASE_CIRCULAR: res_next.result_angle = circ_ang;
      CASE_LINEAR:   res_next.result_angle = fe.lin;
      default:       res_next.result_angle = fe.direct;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= vec_v[CORDIC_STAGES];
    end
  end

  always_ff @(posedge clk) begin
    result <= res_next;
  end

endmodule

FILE: rtl/core/cai_div_cell.sv
// one restoring division step of the ratio divider chain
// depends on cai_pkg
module cai_div_cell (
  input  logic         clk,
  input  logic         en,
  input  logic         bit_in,
  input  cai_pkg::div_t d,
  output cai_pkg::div_t q
);
  import cai_pkg::*;

  logic [POS_W:0] trial;
  logic [POS_W:0] diff;
  logic           ge;
  div_t           q_next;

  always_comb begin
    trial  = {d.rem, bit_in};
    diff   = trial - {1'b0, d.den};
    ge     = trial >= {1'b0, d.den};
    q_next = d;
    if (en) begin
      q_next.rem = ge ? diff[POS_W-1:0] : trial[POS_W-1:0];
      q_next.quo = {d.quo[RATIO_W-2:0], ge};
    end
  end

  always_ff @(posedge clk) begin
    q <= q_next;
  end

endmodule

FILE: rtl/core/cai_rot_cell.sv
// one cordic rotation step, angle to vector
// depends on cai_pkg
module cai_rot_cell (
  input  logic                     clk,
  input  logic                     en,
  input  logic [cai_pkg::SH_W-1:0] idx,
  input  cai_pkg::vec_t            v,
  output cai_pkg::vec_t            q
);
  import cai_pkg::*;

  logic signed [CW-1:0] x, y, z, xs, ys, at;
  vec_t                 q_next;

  always_comb begin
    x  = v.x;
    y  = v.y;
    z  = v.z;
    xs = x >>> idx;
    ys = y >>> idx;
    at = atan_q30(idx);
    q_next = v;
    if (en) begin
      if (!z[CW-1]) begin
        q_next.x = x - ys;
        q_next.y = y + xs;
        q_next.z = z - at;
      end else begin
        q_next.x = x + ys;
        q_next.y = y - xs;
        q_next.z = z + at;
      end
    end
  end

  always_ff @(posedge clk) begin
    q <= q_next;
  end

endmodule

FILE: rtl/core/cai_vec_cell.sv
// one cordic vectoring step, vector to angle
// depends on cai_pkg
module cai_vec_cell (
  input  logic                     clk,
  input  logic [cai_pkg::SH_W-1:0] idx,
  input  cai_pkg::vec_t            v,
  output cai_pkg::vec_t            q
);
  import cai_pkg::*;

  logic signed [CW-1:0] x, y, z, xs, ys, at;
  vec_t                 q_next;

  always_comb begin
    x  = v.x;
    y  = v.y;
    z  = v.z;
    xs = x >>> idx;
    ys = y >>> idx;
    at = atan_q30(idx);
    if (!y[CW-1]) begin
      q_next.x = x + ys;
      q_next.y = y - xs;
      q_next.z = z + at;
    end else begin
      q_next.x = x - ys;
      q_next.y = y + xs;
      q_next.z = z - at;
    end
  end

  always_ff @(posedge clk) begin
    q <= q_next;
  end

endmodule

FILE: rtl/core/cai_checker.sv
// port-level checks of the angle interpolator, bound to the top level
// depends on cai_pkg and circular_angle_interpolator_unit_macros.svh
`include "circular_angle_interpolator_unit_macros.svh"

module cai_checker (
  input logic          clk,
  input logic          rst,
  input logic          start,
  input logic          busy,
  input logic          done,
  input cai_pkg::res_t result
);
  import cai_pkg::*;

  // every result goes back to a transaction taken a fixed time earlier
  `CAI_ASSERT(a_done_has_start, clk, rst, (done |-> $past(start && !busy, LATENCY)))
  `CAI_ASSERT(a_code_range, clk, rst, (done |-> result.case_code <= CASE_CIRCULAR))
  // a ratio fault only comes from an interpolated answer
  `CAI_ASSERT(a_fault_interp, clk, rst, ((done && result.ratio_fault) |-> (result.case_code == CASE_LINEAR || result.case_code == CASE_CIRCULAR)))
  `CAI_ASSERT_ALWAYS(a_reset_quiet, clk, ($past(rst) |-> !done))

endmodule

bind circular_angle_interpolator_unit cai_checker u_cai_checker (.*);
